>>> rtl/aesc_pkg.sv
// ----------------------------------------------------------------------------
// aesc_pkg: shared types and GF(2^8) helpers
// S-box tables, column mixing and key register indexes for the AES core.
// ----------------------------------------------------------------------------
package aesc_pkg;

   localparam int KeyEntries = 30;
   localparam int KeyAddrW   = 5;

   localparam logic [2:0] REG_MODE = 3'd0;
   localparam logic [2:0] REG_KEY0 = 3'd1;
   localparam logic [2:0] REG_KEY1 = 3'd2;
   localparam logic [2:0] REG_KEY2 = 3'd3;
   localparam logic [2:0] REG_KEY3 = 3'd4;

   localparam logic OP_ENCRYPT = 1'b0;
   localparam logic OP_DECRYPT = 1'b1;

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xt(x);
      end
      gmul = p;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   localparam logic [7:0] ISBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // InvMixColumns over a 128-bit state, byte 0 in the top bits
   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         o[127-32*c -: 8] = gmul(a0,8'd14)^gmul(a1,8'd11)^gmul(a2,8'd13)^gmul(a3,8'd9);
         o[119-32*c -: 8] = gmul(a0,8'd9)^gmul(a1,8'd14)^gmul(a2,8'd11)^gmul(a3,8'd13);
         o[111-32*c -: 8] = gmul(a0,8'd13)^gmul(a1,8'd9)^gmul(a2,8'd14)^gmul(a3,8'd11);
         o[103-32*c -: 8] = gmul(a0,8'd11)^gmul(a1,8'd13)^gmul(a2,8'd9)^gmul(a3,8'd14);
      end
      inv_mix = o;
   endfunction

   function automatic logic [127:0] fwd_mix(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         o[127-32*c -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
         o[119-32*c -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
         o[111-32*c -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
         o[103-32*c -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
      end
      fwd_mix = o;
   endfunction

   typedef struct packed {
      logic       decrypt;
      logic       last;
   } round_ctl_type;

endpackage

>>> rtl/aes_block_cipher_128_256_core.sv
// ----------------------------------------------------------------------------
// aes_block_cipher_128_256_core: AES-128/256 block cipher, one block per transfer
// Key schedule expanded into RAM on demand, one shared round unit iterated.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  req     | in        | req_valid, req_stall, req_opcode, req_block_high/low
//  rsp     | out       | rsp_valid, rsp_stall, rsp_result_high/low
//  csr     | in        | APB: psel penable pwrite paddr pwdata prdata pready
//
// Steps: the initial key add reads the two 64-bit key halves from the
// single-port RAM in turn (KRD0, KRD1) and assembles the key (KGET); each
// round runs these three states and then the round itself (RND). The
// result waits in OUT with rsp_valid high; only IDLE takes the next block.
// After a key or mode write the first block first runs the schedule:
// 4*(Nr+1) word steps, then DRD0, DRD1, DWR0, DWR1 per decryption key.
// Reset clears FSM, mode, keys and ready flag; key RAMs hold garbage until expanded.
// A result held under rsp_stall keeps the core busy; req_stall is high then.
// ----------------------------------------------------------------------------
module aes_block_cipher_128_256_core
   import aesc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         req_opcode,
   input  logic [63:0]  req_block_high,
   input  logic [63:0]  req_block_low,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [63:0]  rsp_result_high,
   output logic [63:0]  rsp_result_low,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_EXP    = 4'd1;  // one schedule word per cycle
   localparam logic [3:0] ST_DRD0   = 4'd2;  // dec key: read enc half 0
   localparam logic [3:0] ST_DRD1   = 4'd3;
   localparam logic [3:0] ST_DWR0   = 4'd4;
   localparam logic [3:0] ST_DWR1   = 4'd5;
   localparam logic [3:0] ST_KRD0   = 4'd6;  // cipher: read key half 0
   localparam logic [3:0] ST_KRD1   = 4'd7;
   localparam logic [3:0] ST_KGET   = 4'd8;
   localparam logic [3:0] ST_RND    = 4'd9;
   localparam logic [3:0] ST_OUT    = 4'd10;

   logic [3:0]   state_ff, state_in;
   logic         mode_ff;
   logic [63:0]  key_ff [4];
   logic         ready_ff;
   logic         nr_mode_ff;            // mode latched for the schedule in use
   logic         op_ff;
   logic [127:0] blk_ff, blk_in;
   logic [3:0]   rnd_ff, rnd_in;        // round index 0..14
   logic [5:0]   wi_ff, wi_in;          // schedule word index
   logic [31:0]  win_ff [8];            // last Nk words
   logic [7:0]   rc_ff, rc_in;
   logic [63:0]  half_ff, half_in;
   logic [31:0]  wpend_ff;              // even word awaiting its partner

   logic         csr_wr;
   logic [2:0]   csr_idx;
   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[5:3];

   always_comb begin
      unique case (csr_idx)
         REG_MODE: csr_prdata = {63'd0, mode_ff};
         REG_KEY0: csr_prdata = key_ff[0];
         REG_KEY1: csr_prdata = key_ff[1];
         REG_KEY2: csr_prdata = key_ff[2];
         REG_KEY3: csr_prdata = key_ff[3];
         default:  csr_prdata = 64'd0;
      endcase
   end

   // key RAM ports
   logic              enc_we, dec_we;
   logic [KeyAddrW-1:0] enc_addr, dec_addr;
   logic [63:0]       enc_wdata, dec_wdata, enc_rdata, dec_rdata;

   aesc_ram #(.Width(64), .Depth(KeyEntries)) u_enc_ram (
      .clock(clock), .we(enc_we), .addr(enc_addr), .wdata(enc_wdata), .rdata(enc_rdata));
   aesc_ram #(.Width(64), .Depth(KeyEntries)) u_dec_ram (
      .clock(clock), .we(dec_we), .addr(dec_addr), .wdata(dec_wdata), .rdata(dec_rdata));

   // schedule word generator
   logic [3:0]  nk;
   logic [5:0]  total;
   logic [3:0]  nr;
   logic [31:0] prev, t, wnew;
   logic [2:0]  wmod;
   assign nk    = nr_mode_ff ? 4'd8 : 4'd4;
   assign nr    = nr_mode_ff ? 4'd14 : 4'd10;
   assign total = nr_mode_ff ? 6'd60 : 6'd44;
   assign wmod  = nr_mode_ff ? wi_ff[2:0] : {1'b0, wi_ff[1:0]};
   assign prev  = nr_mode_ff ? win_ff[7] : win_ff[3];

   always_comb begin
      t = prev;
      if (wmod == 3'd0) t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_ff, 24'd0};
      else if (nr_mode_ff && wmod == 3'd4) t = sub_word(prev);
      wnew = (wi_ff < {2'b0, nk}) ? (wi_ff[0] ? key_ff[wi_ff[2:1]][31:0]
                                              : key_ff[wi_ff[2:1]][63:32])
                                  : win_ff[0] ^ t;
   end

   // round unit
   round_ctl_type rctl;
   logic [127:0]  rkey, rout;
   assign rctl.decrypt = op_ff;
   assign rctl.last    = (rnd_ff == nr);
   assign rkey = {half_ff, op_ff ? dec_rdata : enc_rdata};

   aesc_round u_round (.state_in(blk_ff), .round_key(rkey), .ctl(rctl), .state_out(rout));

   logic [3:0] dsrc;
   logic [4:0] kaddr0;
   logic [127:0] dmix;                  // inner decryption keys through InvMixColumns
   assign dsrc   = nr - rnd_ff;
   assign kaddr0 = {rnd_ff, 1'b0};
   assign dmix   = inv_mix({half_ff, enc_rdata});

   always_comb begin
      state_in = state_ff;
      blk_in   = blk_ff;
      rnd_in   = rnd_ff;
      wi_in    = wi_ff;
      rc_in    = rc_ff;
      half_in  = half_ff;
      enc_we   = 1'b0;
      dec_we   = 1'b0;
      enc_addr = kaddr0;
      dec_addr = kaddr0;
      enc_wdata = {wpend_ff, wnew};
      dec_wdata = 64'd0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               blk_in = {req_block_high, req_block_low};
               rnd_in = 4'd0;
               wi_in  = 6'd0;
               rc_in  = 8'h01;
               state_in = ready_ff ? ST_KRD0 : ST_EXP;
            end
         end
         ST_EXP: begin
            enc_addr = wi_ff[5:1];
            enc_we   = wi_ff[0];
            if (wmod == 3'd0 && wi_ff >= {2'b0, nk}) rc_in = xt(rc_ff);
            wi_in = wi_ff + 6'd1;
            if (wi_ff == total - 6'd1) begin
               rnd_in   = 4'd0;
               state_in = ST_DRD0;
            end
         end
         ST_DRD0: begin
            enc_addr = {dsrc, 1'b0};
            state_in = ST_DRD1;
         end
         ST_DRD1: begin
            enc_addr = {dsrc, 1'b1};
            half_in  = enc_rdata;
            state_in = ST_DWR0;
         end
         ST_DWR0: begin
            // both halves now present: half_ff and enc_rdata
            blk_in   = blk_ff;
            state_in = ST_DWR1;
            dec_we   = 1'b1;
            dec_wdata = (rnd_ff == 4'd0 || rnd_ff == nr) ? half_ff : dmix[127:64];
            half_in  = (rnd_ff == 4'd0 || rnd_ff == nr) ? enc_rdata : dmix[63:0];
         end
         ST_DWR1: begin
            dec_addr  = {rnd_ff, 1'b1};
            dec_we    = 1'b1;
            dec_wdata = half_ff;
            if (rnd_ff == nr) begin
               rnd_in   = 4'd0;
               state_in = ST_KRD0;
            end else begin
               rnd_in   = rnd_ff + 4'd1;
               state_in = ST_DRD0;
            end
         end
         ST_KRD0: begin
            state_in = ST_KRD1;
         end
         ST_KRD1: begin
            enc_addr = {rnd_ff, 1'b1};
            dec_addr = {rnd_ff, 1'b1};
            half_in  = op_ff ? dec_rdata : enc_rdata;
            state_in = ST_KGET;
         end
         ST_KGET: begin
            enc_addr = {rnd_ff, 1'b1};
            dec_addr = {rnd_ff, 1'b1};
            if (rnd_ff == 4'd0) begin
               blk_in   = blk_ff ^ rkey;
               rnd_in   = 4'd1;
               state_in = ST_KRD0;
            end else begin
               state_in = ST_RND;
            end
         end
         ST_RND: begin
            enc_addr = {rnd_ff, 1'b1};
            dec_addr = {rnd_ff, 1'b1};
            blk_in = rout;
            if (rnd_ff == nr) state_in = ST_OUT;
            else begin
               rnd_in   = rnd_ff + 4'd1;
               state_in = ST_KRD0;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= 1'b0;
         ready_ff <= 1'b0;
         for (int i = 0; i < 4; i++) key_ff[i] <= 64'd0;
      end else begin
         state_ff <= state_in;
         if (csr_wr) begin
            unique case (csr_idx)
               REG_MODE: begin mode_ff <= csr_pwdata[0]; ready_ff <= 1'b0; end
               REG_KEY0: begin key_ff[0] <= csr_pwdata; ready_ff <= 1'b0; end
               REG_KEY1: begin key_ff[1] <= csr_pwdata; ready_ff <= 1'b0; end
               REG_KEY2: begin key_ff[2] <= csr_pwdata; ready_ff <= 1'b0; end
               REG_KEY3: begin key_ff[3] <= csr_pwdata; ready_ff <= 1'b0; end
               default: ;
            endcase
         end else if (state_ff == ST_DWR1 && rnd_ff == nr) begin
            ready_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      rnd_ff  <= rnd_in;
      wi_ff   <= wi_in;
      rc_ff   <= rc_in;
      half_ff <= half_in;
      if (state_ff == ST_IDLE && req_valid) begin
         op_ff <= req_opcode;
         if (!ready_ff) nr_mode_ff <= mode_ff;
      end
      if (state_ff == ST_EXP) begin
         wpend_ff <= wnew;
         // AES-128 keeps its window in entries 0..3
         for (int i = 0; i < 7; i++)
            win_ff[i] <= (!nr_mode_ff && i == 3) ? wnew : win_ff[i+1];
         win_ff[7] <= wnew;
      end
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_result_high = blk_ff[127:64];
   assign rsp_result_low  = blk_ff[63:0];
endmodule

>>> rtl/aesc_ram.sv
// ----------------------------------------------------------------------------
// aesc_ram: generic single-port RAM
// One access per cycle: the write, if any, plus a read of the old contents; registered read data.
// ----------------------------------------------------------------------------
module aesc_ram #(
   parameter int Width = 64,
   parameter int Depth = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wdata,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[addr] <= wdata;
      rdata_ff <= mem_ff[addr];
   end
   assign rdata = rdata_ff;
endmodule

>>> rtl/aesc_round.sv
// ----------------------------------------------------------------------------
// aesc_round: one AES round, forward or inverse
// Sub bytes, shift rows, optional mix columns, then the round key add.
// ----------------------------------------------------------------------------
module aesc_round
   import aesc_pkg::*;
(
   input  logic [127:0]  state_in,
   input  logic [127:0]  round_key,
   input  round_ctl_type ctl,
   output logic [127:0]  state_out
);
   logic [7:0]   sb [16];
   logic [7:0]   sr [16];
   logic [127:0] srv;
   logic [127:0] mixed;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         sb[i] = ctl.decrypt ? ISBOX[state_in[127-8*i -: 8]] : SBOX[state_in[127-8*i -: 8]];
      end
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            if (ctl.decrypt) sr[r + 4*((c + r) % 4)] = sb[r + 4*c];
            else sr[r + 4*c] = sb[r + 4*((c + r) % 4)];
         end
      end
      for (int i = 0; i < 16; i++) srv[127-8*i -: 8] = sr[i];
      mixed = ctl.decrypt ? inv_mix(srv) : fwd_mix(srv);
      state_out = (ctl.last ? srv : mixed) ^ round_key;
   end
endmodule

>>> rtl/aesc_checker.sv
// ----------------------------------------------------------------------------
// aesc_checker: port-level checks for the AES core
// Handshake and occupancy rules seen from the top level's ports.
// ----------------------------------------------------------------------------
module aesc_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [63:0]  rsp_result_high,
   input logic         csr_pready
);
   // a held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_high))
      else $error("result changed under stall");

   // no new request is taken while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted with result pending");

   // an accepted request cannot answer in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !rsp_valid)
      else $error("result too early");

   a_pready: assert property (@(posedge clock) csr_pready)
      else $error("pready low");
endmodule

bind aes_block_cipher_128_256_core aesc_checker u_aesc_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_result_high(rsp_result_high),
   .csr_pready(csr_pready));
